// ===== design/srie_pkg.sv =====
// shared types, codes and decode helpers for the small risc instruction executor
// used by every module of the block except srie_ram; depends on nothing
`timescale 1ns / 1ps

package srie_pkg;

  // sizes and reset values
  localparam int unsigned REG_COUNT      = 32;
  localparam int unsigned REG_AW         = $clog2(REG_COUNT);
  localparam int unsigned DEF_DATA_WORDS = 64;
  localparam logic [31:0] START_PC_RESET = 32'd128;

  // item kinds
  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INSTR = 2'd1;
  localparam logic [1:0] ERR_ADDR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_START_PC  = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  // instruction categories
  localparam logic [2:0] CAT_BASE = 3'd0;
  localparam logic [2:0] CAT_REG  = 3'd6;
  localparam logic [2:0] CAT_IMM  = 3'd7;

  // base category opcodes
  localparam logic [2:0] OPC_J     = 3'd0;
  localparam logic [2:0] OPC_BEQ   = 3'd2;
  localparam logic [2:0] OPC_BGTZ  = 3'd4;
  localparam logic [2:0] OPC_BREAK = 3'd5;
  localparam logic [2:0] OPC_SW    = 3'd6;
  localparam logic [2:0] OPC_LW    = 3'd7;

  // register alu codes
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_MUL = 3'd2;
  localparam logic [2:0] ALU_AND = 3'd3;
  localparam logic [2:0] ALU_OR  = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_NOR = 3'd6;

  // immediate alu codes
  localparam logic [2:0] IMM_ADD = 3'd0;
  localparam logic [2:0] IMM_AND = 3'd1;
  localparam logic [2:0] IMM_OR  = 3'd2;
  localparam logic [2:0] IMM_XOR = 3'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  // input word
  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        instr_word;
    logic [5:0]         mem_index;
    logic signed [31:0] mem_value;
  } in_t;

  // result word
  typedef struct packed {
    logic [31:0]        next_pc;
    logic               halted;
    logic               reg_written;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic signed [31:0] read_value;
    logic [1:0]         error;
  } out_t;

  // execute stage decisions handed to the sequencer
  typedef struct packed {
    logic [31:0] pc_next;
    logic        halt_next;
    logic        reg_we;
    logic        is_load;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        mem_we;
    logic [29:0] mem_idx;
    logic [31:0] mem_wdata;
    logic [31:0] read_value;
    logic [1:0]  error;
  } exec_t;

  // source register fields depend on the category
  function automatic logic [4:0] rs_of(input logic [31:0] iw);
    rs_of = (iw[31:29] == CAT_BASE) ? iw[25:21] : iw[28:24];
  endfunction

  function automatic logic [4:0] rt_of(input logic [31:0] iw);
    rt_of = (iw[31:29] == CAT_BASE) ? iw[20:16] : iw[23:19];
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== design/small_risc_instruction_executor.sv =====
// Executes one word per command: accepted at start, execute state, then result strobe.
// For LW the data ram is read in the execute state and the word is taken in a load state.
// A new word is taken only after the previous word has left execute (and load) state.
// Reset: pc to 128, halt cleared, register file reads zero at once via per-entry valid bits;
// data memory is undefined until written. The receiver cannot stall; busy high while working.
// depends on srie_pkg, srie_ram and srie_exec
`timescale 1ns / 1ps

module small_risc_instruction_executor #(
  parameter int unsigned DATA_WORDS = srie_pkg::DEF_DATA_WORDS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  srie_pkg::in_t  in_i,
  output logic           res_valid_o,
  output srie_pkg::out_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned RAW = srie_pkg::REG_AW;

  srie_pkg::state_e state_q, state_d;
  srie_pkg::in_t    item_q;
  srie_pkg::out_t   res_q;
  srie_pkg::exec_t  ex;

  logic [31:0]          pc_q, base_q;
  logic                 halt_q, res_valid_q;
  logic [srie_pkg::REG_COUNT-1:0] rvalid_q;
  logic                 rs_ok_q, rt_ok_q;
  logic                 accept, cfg_we;
  logic [31:0]          rs_raw, rt_raw, rs_val, rt_val;
  logic [RAW-1:0]       rs_addr, rt_addr;
  logic                 rf_we;
  logic [RAW-1:0]       rf_waddr;
  logic [31:0]          rf_wdata;
  logic                 dm_we, dm_re;
  logic [DAW-1:0]       dm_raddr;
  logic [31:0]          dm_rdata;

  assign accept  = start && !busy;
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign rs_addr = srie_pkg::rs_of(in_i.instr_word);
  assign rt_addr = srie_pkg::rt_of(in_i.instr_word);

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srie_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_d     = state_q;
    busy        = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      srie_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cfg_ready_o = 1'b1;
        if (start) state_d = srie_pkg::ST_EXEC;
      end
      srie_pkg::ST_EXEC: begin
        state_d = ex.is_load ? srie_pkg::ST_LOAD : srie_pkg::ST_IDLE;
      end
      srie_pkg::ST_LOAD: begin
        state_d = srie_pkg::ST_IDLE;
      end
      default: state_d = srie_pkg::ST_IDLE;
    endcase
  end

  // register file: two mirrored copies give both source reads in the same cycle
  srie_ram #(.WIDTH(32), .DEPTH(srie_pkg::REG_COUNT)) u_rf_rs (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (accept),
    .raddr_i (rs_addr),
    .rdata_o (rs_raw)
  );

  srie_ram #(.WIDTH(32), .DEPTH(srie_pkg::REG_COUNT)) u_rf_rt (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (accept),
    .raddr_i (rt_addr),
    .rdata_o (rt_raw)
  );

  // entries never written since reset read as zero
  assign rs_val = rs_ok_q ? rs_raw : 32'd0;
  assign rt_val = rt_ok_q ? rt_raw : 32'd0;

  // data memory
  srie_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (ex.mem_idx[DAW-1:0]),
    .wdata_i (ex.mem_wdata),
    .re_i    (dm_re),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  srie_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
    .item_i    (item_q),
    .pc_i      (pc_q),
    .halted_i  (halt_q),
    .rs_val_i  (rs_val),
    .rt_val_i  (rt_val),
    .base_i    (base_q),
    .rd_data_i (dm_rdata),
    .exec_o    (ex)
  );

  // ram port steering: readback address at accept, load address in execute
  always_comb begin
    dm_we    = (state_q == srie_pkg::ST_EXEC) && ex.mem_we;
    dm_re    = (accept && in_i.op == srie_pkg::OP_READ) ||
               ((state_q == srie_pkg::ST_EXEC) && ex.is_load);
    dm_raddr = accept ? DAW'(in_i.mem_index) : ex.mem_idx[DAW-1:0];
    rf_we    = 1'b0;
    rf_waddr = ex.reg_idx;
    rf_wdata = ex.reg_val;
    if (state_q == srie_pkg::ST_EXEC) begin
      rf_we = ex.reg_we && !ex.is_load;
    end else if (state_q == srie_pkg::ST_LOAD) begin
      rf_we    = 1'b1;
      rf_waddr = res_q.reg_index;
      rf_wdata = dm_rdata;
    end
  end

  // architectural and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= srie_pkg::START_PC_RESET;
      base_q      <= '0;
      halt_q      <= 1'b0;
      rvalid_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ((state_q == srie_pkg::ST_EXEC) && !ex.is_load) ||
                     (state_q == srie_pkg::ST_LOAD);
      if (rf_we) rvalid_q[rf_waddr] <= 1'b1;
      if (state_q == srie_pkg::ST_EXEC) begin
        pc_q   <= ex.pc_next;
        halt_q <= ex.halt_next;
      end
      if (cfg_we) begin
        case (cfg_index_i)
          srie_pkg::CFG_START_PC: begin
            pc_q <= cfg_data_i;
          end
          srie_pkg::CFG_DATA_BASE: base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // captured word, source valid flags and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_i;
      rs_ok_q <= rvalid_q[rs_addr];
      rt_ok_q <= rvalid_q[rt_addr];
    end
    if (state_q == srie_pkg::ST_EXEC) begin
      res_q.next_pc     <= ex.pc_next;
      res_q.halted      <= ex.halt_next;
      res_q.reg_written <= ex.reg_we;
      res_q.reg_index   <= ex.reg_idx;
      res_q.reg_value   <= ex.reg_val;
      res_q.mem_written <= ex.mem_we;
      res_q.read_value  <= ex.read_value;
      res_q.error       <= ex.error;
    end else if (state_q == srie_pkg::ST_LOAD) begin
      res_q.reg_value <= dm_rdata;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/srie_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module srie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/srie_exec.sv =====
// execute stage: decode, alu, branch targets and data address check
// depends on srie_pkg
`timescale 1ns / 1ps

module srie_exec #(
  parameter int unsigned DATA_WORDS = srie_pkg::DEF_DATA_WORDS
) (
  input  srie_pkg::in_t   item_i,
  input  logic [31:0]     pc_i,
  input  logic            halted_i,
  input  logic [31:0]     rs_val_i,
  input  logic [31:0]     rt_val_i,
  input  logic [31:0]     base_i,
  input  logic [31:0]     rd_data_i,
  output srie_pkg::exec_t exec_o
);

  localparam logic [31:0] WORDS = 32'(DATA_WORDS);

  logic [31:0] iw;
  logic [2:0]  cat;
  logic [2:0]  opc_base;
  logic [2:0]  opc_alu;
  logic [31:0] off;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic [31:0] diff;
  logic [31:0] prod;
  logic        addr_ok;
  logic        idx_ok;

  assign iw       = item_i.instr_word;
  assign cat      = iw[31:29];
  assign opc_base = iw[28:26];
  assign opc_alu  = iw[18:16];
  assign off      = srie_pkg::sext16(iw[15:0]);
  assign pc4      = pc_i + 32'd4;
  assign br_tgt   = pc4 + {off[29:0], 2'b00};
  assign diff     = rs_val_i + off - base_i;
  assign addr_ok  = {2'b00, diff[31:2]} < WORDS;
  assign idx_ok   = {26'd0, item_i.mem_index} < WORDS;
  assign prod     = rs_val_i * rt_val_i;

  // decode and execute
  always_comb begin
    exec_o            = '0;
    exec_o.pc_next    = pc_i;
    exec_o.halt_next  = halted_i;
    exec_o.mem_wdata  = rt_val_i;
    exec_o.mem_idx    = diff[31:2];
    case (item_i.op)
      srie_pkg::OP_WRITE: begin
        exec_o.mem_idx   = {24'd0, item_i.mem_index};
        exec_o.mem_wdata = item_i.mem_value;
        if (idx_ok) begin
          exec_o.mem_we = 1'b1;
        end else begin
          exec_o.error = srie_pkg::ERR_ADDR;
        end
      end
      srie_pkg::OP_READ: begin
        if (idx_ok) begin
          exec_o.read_value = rd_data_i;
        end else begin
          exec_o.error = srie_pkg::ERR_ADDR;
        end
      end
      srie_pkg::OP_EXEC: begin
        if (!halted_i) begin
          exec_o.pc_next = pc4;
          case (cat)
            srie_pkg::CAT_BASE: begin
              case (opc_base)
                srie_pkg::OPC_J: begin
                  exec_o.pc_next = {iw[29:0], 2'b00} & 32'h0FFF_FFFC;
                end
                srie_pkg::OPC_BEQ: begin
                  if (rs_val_i == rt_val_i) exec_o.pc_next = br_tgt;
                end
                srie_pkg::OPC_BGTZ: begin
                  if (!rs_val_i[31] && rs_val_i != 32'd0) exec_o.pc_next = br_tgt;
                end
                srie_pkg::OPC_BREAK: begin
                  exec_o.halt_next = 1'b1;
                end
                srie_pkg::OPC_SW: begin
                  if (addr_ok) begin
                    exec_o.mem_we = 1'b1;
                  end else begin
                    exec_o.error = srie_pkg::ERR_ADDR;
                  end
                end
                srie_pkg::OPC_LW: begin
                  if (addr_ok) begin
                    exec_o.reg_we  = 1'b1;
                    exec_o.is_load = 1'b1;
                    exec_o.reg_idx = iw[20:16];
                  end else begin
                    exec_o.error = srie_pkg::ERR_ADDR;
                  end
                end
                default: exec_o.error = srie_pkg::ERR_INSTR;
              endcase
            end
            srie_pkg::CAT_REG: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_idx = iw[15:11];
              case (opc_alu)
                srie_pkg::ALU_ADD: exec_o.reg_val = rs_val_i + rt_val_i;
                srie_pkg::ALU_SUB: exec_o.reg_val = rs_val_i - rt_val_i;
                srie_pkg::ALU_MUL: exec_o.reg_val = prod;
                srie_pkg::ALU_AND: exec_o.reg_val = rs_val_i & rt_val_i;
                srie_pkg::ALU_OR:  exec_o.reg_val = rs_val_i | rt_val_i;
                srie_pkg::ALU_XOR: exec_o.reg_val = rs_val_i ^ rt_val_i;
                srie_pkg::ALU_NOR: exec_o.reg_val = ~(rs_val_i | rt_val_i);
                default: begin
                  exec_o.reg_we  = 1'b0;
                  exec_o.reg_idx = 5'd0;
                  exec_o.error   = srie_pkg::ERR_INSTR;
                end
              endcase
            end
            srie_pkg::CAT_IMM: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_idx = iw[23:19];
              case (opc_alu)
                srie_pkg::IMM_ADD: exec_o.reg_val = rs_val_i + {16'd0, iw[15:0]};
                srie_pkg::IMM_AND: exec_o.reg_val = rs_val_i & {16'd0, iw[15:0]};
                srie_pkg::IMM_OR:  exec_o.reg_val = rs_val_i | {16'd0, iw[15:0]};
                srie_pkg::IMM_XOR: exec_o.reg_val = rs_val_i ^ {16'd0, iw[15:0]};
                default: begin
                  exec_o.reg_we  = 1'b0;
                  exec_o.reg_idx = 5'd0;
                  exec_o.error   = srie_pkg::ERR_INSTR;
                end
              endcase
            end
            default: exec_o.error = srie_pkg::ERR_INSTR;
          endcase
        end
      end
      default: exec_o.error = srie_pkg::ERR_INSTR;
    endcase
  end

endmodule

// ===== design/srie_checker.sv =====
// port-level checks of command timing and result consistency, bound to the top level
// depends on srie_pkg and small_risc_instruction_executor
`timescale 1ns / 1ps

module srie_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input srie_pkg::in_t  in_i,
  input logic           res_valid_o,
  input srie_pkg::out_t res_o,
  input logic           cfg_valid_i,
  input logic           cfg_ready_o,
  input logic           cfg_index_i,
  input logic [31:0]    cfg_data_i
);

  // an accepted word keeps the block busy, with no result, in its execute state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("block not busy right after accepting a word");

  // a result is a single-cycle strobe
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe lasted more than one cycle");

  // results appear only once the block is free again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  // an out-of-range access writes nothing
  a_addr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.error == srie_pkg::ERR_ADDR) |->
      (!res_o.mem_written && !res_o.reg_written))
    else $error("write reported with an address error");

  // configuration is not taken while a word is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o)
    else $error("configuration ready while busy");

endmodule

bind small_risc_instruction_executor srie_checker u_srie_checker (.*);

// ===== verif/srie_checker.sv =====
// result checker for the small risc instruction executor: keeps its own copy of the
// register file, data memory, pc and halt flag and compares every result word
// depends on srie_pkg for the command and result word types and the decode codes
`timescale 1ns / 1ps

module srie_result_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  srie_pkg::in_t  in_i,
  input  logic           res_valid_i,
  input  srie_pkg::out_t res_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    open_count_o
);
  import srie_pkg::*;

  localparam int unsigned MEM_WORDS = DEF_DATA_WORDS;

  // shadow of the architectural state
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] pc;
  logic        halt;
  logic [31:0] data_base;

  out_t        expected_results [$];
  int unsigned fail_count;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // data address to word index, out of range when the index reaches the memory size
  function automatic logic [31:0] word_index(input logic [31:0] addr);
    word_index = (addr - data_base) >> 2;
  endfunction

  // execute one command word on the shadow state and return the result it causes
  function automatic out_t expected_result_of(input in_t w);
    out_t        r;
    logic [31:0] iw;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] npc;
    logic [31:0] off;
    logic [31:0] widx;
    logic [31:0] res;
    logic [2:0]  cat;
    logic [2:0]  opc;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic        ok;
    r  = '0;
    iw = w.instr_word;
    case (op_e'(w.op))
      OP_WRITE: begin
        if (w.mem_index >= MEM_WORDS) begin
          r.error = ERR_ADDR;
        end else begin
          dmem[w.mem_index] = w.mem_value;
          r.mem_written = 1'b1;
        end
      end
      OP_READ: begin
        if (w.mem_index >= MEM_WORDS) r.error = ERR_ADDR;
        else r.read_value = dmem[w.mem_index];
      end
      OP_BAD: r.error = ERR_INSTR;
      default: begin
        if (!halt) begin
          cat = iw[31:29];
          pc4 = pc + 32'd4;
          npc = pc4;
          if (cat == CAT_BASE) begin
            opc = iw[28:26];
            rs  = iw[25:21];
            rt  = iw[20:16];
            off = {{16{iw[15]}}, iw[15:0]};
            a   = gpr[rs];
            b   = gpr[rt];
            case (opc)
              OPC_J:     npc = {4'b0, iw[25:0], 2'b00};
              OPC_BEQ:   if (a == b) npc = pc4 + (off << 2);
              OPC_BGTZ:  if ($signed(a) > 0) npc = pc4 + (off << 2);
              OPC_BREAK: halt = 1'b1;
              OPC_SW: begin
                widx = word_index(a + off);
                if (widx < MEM_WORDS) begin
                  dmem[widx] = b;
                  r.mem_written = 1'b1;
                end else begin
                  r.error = ERR_ADDR;
                end
              end
              OPC_LW: begin
                widx = word_index(a + off);
                if (widx < MEM_WORDS) begin
                  gpr[rt]       = dmem[widx];
                  r.reg_written = 1'b1;
                  r.reg_index   = rt;
                  r.reg_value   = dmem[widx];
                end else begin
                  r.error = ERR_ADDR;
                end
              end
              default: r.error = ERR_INSTR;
            endcase
          end else if (cat == CAT_REG || cat == CAT_IMM) begin
            rs  = iw[28:24];
            rt  = iw[23:19];
            opc = iw[18:16];
            a   = gpr[rs];
            ok  = 1'b1;
            res = '0;
            if (cat == CAT_REG) begin
              rd = iw[15:11];
              b  = gpr[rt];
              case (opc)
                ALU_ADD: res = a + b;
                ALU_SUB: res = a - b;
                ALU_MUL: res = a * b;
                ALU_AND: res = a & b;
                ALU_OR:  res = a | b;
                ALU_XOR: res = a ^ b;
                ALU_NOR: res = ~(a | b);
                default: ok = 1'b0;
              endcase
            end else begin
              // immediate forms write rt, immediate is zero-extended
              rd = rt;
              b  = {16'h0, iw[15:0]};
              case (opc)
                IMM_ADD: res = a + b;
                IMM_AND: res = a & b;
                IMM_OR:  res = a | b;
                IMM_XOR: res = a ^ b;
                default: ok = 1'b0;
              endcase
            end
            if (ok) begin
              gpr[rd]       = res;
              r.reg_written = 1'b1;
              r.reg_index   = rd;
              r.reg_value   = res;
            end else begin
              r.error = ERR_INSTR;
            end
          end else begin
            r.error = ERR_INSTR;
          end
          pc = npc;
        end
      end
    endcase
    r.next_pc = pc;
    r.halted  = halt;
    return r;
  endfunction

  // compare one result word with the oldest expectation
  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", got.next_pc, '0);
    end else begin
      want = expected_results.pop_front();
      if (got.next_pc !== want.next_pc)
        report_mismatch("next_pc", got.next_pc, want.next_pc);
      if (got.halted !== want.halted)
        report_mismatch("halted", got.halted, want.halted);
      if (got.reg_written !== want.reg_written)
        report_mismatch("reg_written", got.reg_written, want.reg_written);
      if (got.reg_index !== want.reg_index)
        report_mismatch("reg_index", got.reg_index, want.reg_index);
      if (got.reg_value !== want.reg_value)
        report_mismatch("reg_value", got.reg_value, want.reg_value);
      if (got.mem_written !== want.mem_written)
        report_mismatch("mem_written", got.mem_written, want.mem_written);
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.error !== want.error)
        report_mismatch("error", got.error, want.error);
    end
  endtask

  // watch the three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
      data_base    = '0;
      pc           = START_PC_RESET;
      halt         = 1'b0;
      expected_results.delete();
      open_count_o <= 0;
    end else begin
      if (res_valid_i) check_result(res_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_START_PC) begin
          pc = cfg_data_i;
        end else begin
          data_base = cfg_data_i;
        end
      end
      if (start_i && !busy_i) expected_results.push_back(expected_result_of(in_i));
      open_count_o <= expected_results.size();
    end
  end

  initial fail_count = 0;

endmodule

// ===== verif/testbench.sv =====
// top of the executor testbench: clock, reset, command and configuration stimulus
// and the verdict; depends on srie_pkg, the executor and srie_result_checker
`timescale 1ns / 1ps

module testbench;
  import srie_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 180;
  localparam int unsigned PHASE_COUNT  = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_t         cmd_word;
  logic        res_strobe;
  out_t        res_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned cycle_cnt;
  int unsigned item_cnt;
  int unsigned sender_idle_pct;
  logic [31:0] cur_base;

  small_risc_instruction_executor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (cmd_word),
    .res_valid_o (res_strobe),
    .res_o       (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  srie_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (cmd_word),
    .res_valid_i  (res_strobe),
    .res_i        (res_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // instruction encoders
  function automatic logic [31:0] enc_reg(input logic [2:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd);
    return {CAT_REG, rs, rt, fn, rd, 11'($urandom)};
  endfunction

  function automatic logic [31:0] enc_imm(input logic [2:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
    return {CAT_IMM, rs, rt, fn, imm};
  endfunction

  function automatic logic [31:0] enc_base(input logic [2:0] opc, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
    return {CAT_BASE, opc, rs, rt, imm};
  endfunction

  // random instruction word, anything but a halt
  function automatic logic [31:0] rand_instr();
    logic [31:0] iw;
    logic [2:0]  fn;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      iw = enc_reg(3'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
    end else if (sel < 7) begin
      fn = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      iw = enc_imm(fn, 5'($urandom), 5'($urandom), 16'($urandom));
    end else if (sel < 9) begin
      fn = 3'($urandom);
      if (fn == OPC_BREAK) fn = OPC_BEQ;
      iw = enc_base(fn, 5'($urandom), 5'($urandom), 16'($urandom));
    end else begin
      iw = $urandom;
      if (iw[31:26] == {CAT_BASE, OPC_BREAK}) iw[26] = 1'b0;
    end
    return iw;
  endfunction

  // one command word, with random idle cycles before it
  task automatic send_cmd(input in_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_word <= w;
    item_cnt++;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic issue_instr(input logic [31:0] iw);
    in_t w;
    w.op         = OP_EXEC;
    w.instr_word = iw;
    w.mem_index  = 6'($urandom);
    w.mem_value  = $urandom;
    send_cmd(w);
  endtask

  task automatic mem_cmd(input op_e op, input logic [5:0] idx, input logic [31:0] val);
    in_t w;
    w.op         = op;
    w.instr_word = $urandom;
    w.mem_index  = idx;
    w.mem_value  = val;
    send_cmd(w);
  endtask

  // build a 32-bit constant in r, using s for the 0x10000 multiplier
  task automatic set_reg(input logic [4:0] r, input logic [4:0] s, input logic [31:0] v);
    issue_instr(enc_imm(IMM_AND, r, r, 16'h0));
    if (v[31:16] != 16'h0) begin
      issue_instr(enc_imm(IMM_OR, r, r, v[31:16]));
      issue_instr(enc_imm(IMM_AND, s, s, 16'h0));
      issue_instr(enc_imm(IMM_OR, s, s, 16'h8000));
      issue_instr(enc_reg(ALU_ADD, s, s, s));
      issue_instr(enc_reg(ALU_MUL, r, s, r));
    end
    issue_instr(enc_imm(IMM_OR, r, r, v[15:0]));
  endtask

  // load or store through a base register aimed at the data window
  task automatic mem_access_seq();
    logic [4:0]  r;
    logic [4:0]  s;
    logic [15:0] off;
    logic [31:0] widx;
    logic [31:0] addr;
    r    = 5'($urandom);
    s    = r + 5'($urandom_range(1, 31));
    off  = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
    widx = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(64, 5000))
                                       : 32'($urandom_range(0, 63));
    addr = cur_base + (widx << 2) + 32'($urandom_range(0, 3));
    set_reg(r, s, addr - {{16{off[15]}}, off});
    if ($urandom_range(0, 1) == 0) issue_instr(enc_base(OPC_SW, r, 5'($urandom), off));
    else issue_instr(enc_base(OPC_LW, r, 5'($urandom), off));
  endtask

  // conditional branch on a freshly built operand
  task automatic branch_seq();
    logic [4:0] r;
    logic [4:0] s;
    r = 5'($urandom);
    s = r + 5'($urandom_range(1, 31));
    set_reg(r, s, ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom);
    if ($urandom_range(0, 1) == 0) issue_instr(enc_base(OPC_BGTZ, r, 5'($urandom),
                                                        16'($urandom)));
    else issue_instr(enc_base(OPC_BEQ, r, ($urandom_range(0, 1) == 0) ? r : s,
                              16'($urandom)));
  endtask

  task automatic random_step();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) mem_cmd(OP_WRITE, 6'($urandom), $urandom);
    else if (sel < 20) mem_cmd(OP_READ, 6'($urandom), $urandom);
    else if (sel < 23) mem_cmd(OP_BAD, 6'($urandom), $urandom);
    else if (sel < 45) mem_access_seq();
    else if (sel < 55) branch_seq();
    else issue_instr(rand_instr());
  endtask

  // let every expected result arrive, then a few quiet cycles
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_DATA_BASE) cur_base = v;
  endtask

  function automatic logic [31:0] rand_cfg();
    logic [31:0] v;
    v = $urandom;
    return (v > 32'hFFFF_FFFC) ? 32'hFFFF_FFFC : v;
  endfunction

  // directed commands after the memory fill: registers zero, base 0, pc 128
  task automatic directed_start();
    issue_instr(enc_imm(IMM_ADD, 5'd0, 5'd1, 16'hFFFF));
    issue_instr(enc_reg(ALU_MUL, 5'd1, 5'd1, 5'd2));
    issue_instr(enc_reg(ALU_MUL, 5'd2, 5'd2, 5'd2));
    issue_instr(enc_reg(ALU_SUB, 5'd0, 5'd1, 5'd3));
    issue_instr(enc_reg(ALU_NOR, 5'd0, 5'd0, 5'd4));
    issue_instr(enc_reg(ALU_AND, 5'd4, 5'd1, 5'd5));
    issue_instr(enc_reg(ALU_OR, 5'd3, 5'd1, 5'd6));
    issue_instr(enc_reg(ALU_XOR, 5'd4, 5'd1, 5'd7));
    issue_instr(enc_imm(IMM_AND, 5'd4, 5'd8, 16'h8001));
    issue_instr(enc_imm(IMM_XOR, 5'd4, 5'd9, 16'hFFFF));
    // register zero is an ordinary register
    issue_instr(enc_imm(IMM_ADD, 5'd0, 5'd0, 16'h0004));
    // store to word zero and load word 63 with sign-extended offsets
    issue_instr(enc_base(OPC_SW, 5'd0, 5'd4, 16'hFFFC));
    issue_instr(enc_base(OPC_LW, 5'd0, 5'd10, 16'h00F8));
    // data addresses past the window and below it
    issue_instr(enc_base(OPC_LW, 5'd0, 5'd11, 16'h0100));
    issue_instr(enc_base(OPC_SW, 5'd0, 5'd4, 16'h8000));
    // branches taken and not taken, largest offsets both ways
    issue_instr(enc_base(OPC_BEQ, 5'd0, 5'd0, 16'h7FFF));
    issue_instr(enc_base(OPC_BEQ, 5'd1, 5'd0, 16'h1234));
    issue_instr(enc_base(OPC_BGTZ, 5'd1, 5'd0, 16'h8000));
    issue_instr(enc_base(OPC_BGTZ, 5'd4, 5'd0, 16'h0010));
    issue_instr(enc_base(OPC_BGTZ, 5'd12, 5'd0, 16'h0010));
    issue_instr({CAT_BASE, OPC_J, 26'h3FF_FFFF});
    issue_instr({CAT_BASE, OPC_J, 26'h0});
    // unknown codes and the unused item kind
    issue_instr(enc_reg(3'd7, 5'd1, 5'd2, 5'd13));
    issue_instr(enc_imm(3'd4, 5'd1, 5'd14, 16'h0001));
    issue_instr({3'd5, 29'h0ABC_DEF0});
    issue_instr(enc_base(3'd1, 5'd1, 5'd2, 16'h0));
    issue_instr(enc_base(3'd3, 5'd1, 5'd2, 16'h0));
    mem_cmd(OP_BAD, 6'd0, 32'h0);
    mem_cmd(OP_READ, 6'd0, 32'h0);
    mem_cmd(OP_READ, 6'd63, 32'hFFFF_FFFF);
  endtask

  // cycle limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [31:0] phase_pc [PHASE_COUNT];
    logic [31:0] phase_base [PHASE_COUNT];
    int unsigned sent;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_word        = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_START_PC;
    cfg_data        = '0;
    sender_idle_pct = 28;
    cur_base        = '0;
    item_cnt        = 0;
    phase_pc[0] = 32'hFFFF_FFFC; phase_base[0] = 32'h0;
    phase_pc[1] = 32'h0;         phase_base[1] = 32'hFFFF_FFFC;
    phase_pc[2] = 32'h80;        phase_base[2] = 32'h0000_1000;
    for (int i = 3; i < PHASE_COUNT; i++) begin
      phase_pc[i]   = rand_cfg();
      phase_base[i] = rand_cfg();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every data word gets a value before anything can read it
    for (int i = 0; i < DEF_DATA_WORDS; i++) mem_cmd(OP_WRITE, 6'(i), $urandom);
    directed_start();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      write_cfg(CFG_START_PC, phase_pc[p]);
      write_cfg(CFG_DATA_BASE, phase_base[p]);
      cfg_valid <= 1'b0;
      sender_idle_pct = (p < 2) ? 28 : (p < 4) ? 55 : 0;
      sent = item_cnt;
      while (item_cnt - sent < PHASE_ITEMS) begin
        random_step();
      end
    end

    // halt, then commands after the halt
    issue_instr(enc_base(OPC_BREAK, 5'($urandom), 5'($urandom), 16'($urandom)));
    issue_instr(enc_imm(IMM_ADD, 5'd1, 5'd1, 16'h0001));
    issue_instr(enc_base(OPC_SW, 5'd0, 5'd1, 16'h0));
    mem_cmd(OP_WRITE, 6'd5, 32'h8000_0000);
    mem_cmd(OP_READ, 6'd5, 32'h0);
    mem_cmd(OP_BAD, 6'd63, 32'h7FFF_FFFF);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
